// ----- rtl/core/i2ctfb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2ctfb_pkg
// Shared codes, widths and defaults for the I2C target frame buffer.
// ----------------------------------------------------------------------------
package i2ctfb_pkg;

  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned TX_DEPTH_DEF = 64;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FRAME_LEN_W = 7;
  localparam int unsigned ACTION_W    = 4;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [BYTE_W-1:0] FILLER_BYTE = 8'hFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BUS_ERROR  = 4'd0,
    ACT_ADDR_WRITE = 4'd1,
    ACT_ADDR_READ  = 4'd2,
    ACT_STOP       = 4'd3,
    ACT_WRITE_BYTE = 4'd4,
    ACT_BYTE_REQ   = 4'd5,
    ACT_TAKE_FRAME = 4'd6,
    ACT_RESP_BYTE  = 4'd7,
    ACT_ARM_EMPTY  = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_DONE = 2'd2
  } bus_cmd_t;

endpackage

// ----- rtl/core/i2c_target_frame_buffer.sv -----
// Bus events and host commands give their registered beat in the cycle after acceptance;
// a byte request served from the response store passes its store read register first.
// Take frame: bytes pass the receive store read register, then one byte per cycle while
// the output is not stalled, set by the single read port. One item is in work at a time.
// Reset: synchronous, active low; clears all control state. Both byte stores stay
// undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
// i2c_target_frame_buffer
// Target-side buffer engine: collects host writes into a receive store, parks
// complete frames, holds the bus while a response is pending and streams the
// response with filler.
// ----------------------------------------------------------------------------
module i2c_target_frame_buffer #(
  parameter int unsigned RX_DEPTH = i2ctfb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = i2ctfb_pkg::TX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [i2ctfb_pkg::IN_DATA_W-1:0]   in_tdata,   // data[7:0], host_nack[8], zero
  input  logic [i2ctfb_pkg::ACTION_W-1:0]    in_tuser,   // action[3:0]
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bus_command[1:0], read_byte[9:2], frame_byte[17:10], frame_length[24:18],
  // response_consumed[25], zero
  output logic [i2ctfb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                               out_tuser,  // frame_valid[0]
  output logic                               out_tlast
);

  localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
  localparam int unsigned BW    = i2ctfb_pkg::BYTE_W;
  localparam int unsigned LW    = i2ctfb_pkg::FRAME_LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_TXRD, S_FRAME} state_t;

  logic [BW-1:0] rx_mem [RX_DEPTH];
  logic [BW-1:0] tx_mem [TX_DEPTH];

  state_t              state_r, state_nxt;
  logic [RX_CW-1:0]    rx_count_r, rx_count_nxt;
  logic [RX_CW-1:0]    parked_len_r, parked_len_nxt;
  logic                rx_ovf_r, rx_ovf_nxt;
  logic                parked_r, parked_nxt;
  logic                in_write_r, in_write_nxt;
  logic                awaiting_r, awaiting_nxt;
  logic [TX_CW-1:0]    resp_len_r, resp_len_nxt;
  logic [TX_CW-1:0]    tx_idx_r, tx_idx_nxt;
  logic [TX_CW-1:0]    load_ptr_r, load_ptr_nxt;
  logic                first_tx_r, first_tx_nxt;
  logic                in_read_r, in_read_nxt;
  logic                consumed_r, consumed_nxt;
  logic [RX_CW-1:0]    fr_len_r, fr_len_nxt;
  logic [RX_CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_last_r, pend_last_nxt;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [1:0]          out_cmd_r, out_cmd_nxt;
  logic [BW-1:0]       out_rbyte_r, out_rbyte_nxt;
  logic                out_fvalid_r, out_fvalid_nxt;
  logic [BW-1:0]       out_fbyte_r, out_fbyte_nxt;
  logic [LW-1:0]       out_flen_r, out_flen_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_cons_r, out_cons_nxt;

  logic [BW-1:0]       rx_rdata_r;
  logic [BW-1:0]       tx_rdata_r;

  i2ctfb_pkg::action_t act;
  logic [BW-1:0]       in_data;
  logic                in_nack;
  logic                in_accept;
  logic                out_free;
  logic                rx_we;
  logic                tx_we;
  logic                rx_re;
  logic                tx_re;
  logic                tx_hit;
  logic                emit;
  logic [1:0]          emit_cmd;
  logic [BW-1:0]       emit_rbyte;

  assign act       = i2ctfb_pkg::action_t'(in_tuser);
  assign in_data   = in_tdata[BW-1:0];
  assign in_nack   = in_tdata[BW];
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_accept = in_tvalid && in_tready;

  assign tx_hit = (first_tx_r || !in_nack) && (tx_idx_r < resp_len_r) &&
                  (tx_idx_r < TX_CW'(TX_DEPTH));
  assign rx_we  = in_accept && (act == i2ctfb_pkg::ACT_WRITE_BYTE) && in_write_r &&
                  (rx_count_r < RX_CW'(RX_DEPTH));
  assign tx_we  = in_accept && (act == i2ctfb_pkg::ACT_RESP_BYTE) &&
                  (load_ptr_r < TX_CW'(TX_DEPTH));
  assign tx_re  = in_accept && (act == i2ctfb_pkg::ACT_BYTE_REQ) && tx_hit;
  assign rx_re  = (state_r == S_FRAME) && (rd_idx_r < fr_len_r) && (!pend_r || out_free);

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_count_r[RX_AW-1:0]] <= in_data;
    end
    if (rx_re) begin
      rx_rdata_r <= rx_mem[rd_idx_r[RX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[load_ptr_r[TX_AW-1:0]] <= in_data;
    end
    if (tx_re) begin
      tx_rdata_r <= tx_mem[tx_idx_r[TX_AW-1:0]];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rx_count_nxt   = rx_count_r;
    parked_len_nxt = parked_len_r;
    rx_ovf_nxt     = rx_ovf_r;
    parked_nxt     = parked_r;
    in_write_nxt   = in_write_r;
    awaiting_nxt   = awaiting_r;
    resp_len_nxt   = resp_len_r;
    tx_idx_nxt     = tx_idx_r;
    load_ptr_nxt   = load_ptr_r;
    first_tx_nxt   = first_tx_r;
    in_read_nxt    = in_read_r;
    consumed_nxt   = consumed_r;
    fr_len_nxt     = fr_len_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = pend_r;
    pend_last_nxt  = pend_last_r;

    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_cmd_nxt    = out_cmd_r;
    out_rbyte_nxt  = out_rbyte_r;
    out_fvalid_nxt = out_fvalid_r;
    out_fbyte_nxt  = out_fbyte_r;
    out_flen_nxt   = out_flen_r;
    out_last_nxt   = out_last_r;
    out_cons_nxt   = out_cons_r;

    emit       = 1'b0;
    emit_cmd   = i2ctfb_pkg::CMD_HOLD;
    emit_rbyte = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          emit = 1'b1;
          // close an open write on address match or stop
          if (in_write_r && (act == i2ctfb_pkg::ACT_ADDR_WRITE ||
                             act == i2ctfb_pkg::ACT_ADDR_READ ||
                             act == i2ctfb_pkg::ACT_STOP)) begin
            in_write_nxt = 1'b0;
            if (rx_count_r != '0 && !rx_ovf_r) begin
              parked_nxt     = 1'b1;
              parked_len_nxt = rx_count_r;
            end
            rx_count_nxt = '0;
            rx_ovf_nxt   = 1'b0;
          end
          case (act)
            i2ctfb_pkg::ACT_BUS_ERROR: begin
              rx_count_nxt = '0;
              rx_ovf_nxt   = 1'b0;
              in_write_nxt = 1'b0;
              in_read_nxt  = 1'b0;
              first_tx_nxt = 1'b0;
            end
            i2ctfb_pkg::ACT_ADDR_WRITE, i2ctfb_pkg::ACT_ADDR_READ: begin
              if (!parked_nxt && !awaiting_r) begin
                if (act == i2ctfb_pkg::ACT_ADDR_READ) begin
                  first_tx_nxt = 1'b1;
                  tx_idx_nxt   = '0;
                  in_read_nxt  = 1'b1;
                end else begin
                  in_write_nxt = 1'b1;
                  rx_count_nxt = '0;
                  rx_ovf_nxt   = 1'b0;
                  resp_len_nxt = '0;
                end
                emit_cmd = i2ctfb_pkg::CMD_ACK;
              end
            end
            i2ctfb_pkg::ACT_STOP: begin
              if (in_read_r) begin
                in_read_nxt  = 1'b0;
                first_tx_nxt = 1'b0;
                if (resp_len_r != '0 && tx_idx_r >= resp_len_r) begin
                  consumed_nxt = 1'b1;
                end
              end
              emit_cmd = i2ctfb_pkg::CMD_DONE;
            end
            i2ctfb_pkg::ACT_WRITE_BYTE: begin
              if (in_write_r) begin
                if (rx_count_r < RX_CW'(RX_DEPTH)) begin
                  rx_count_nxt = rx_count_r + RX_CW'(1);
                end else begin
                  rx_ovf_nxt = 1'b1;
                end
              end
              emit_cmd = i2ctfb_pkg::CMD_ACK;
            end
            i2ctfb_pkg::ACT_BYTE_REQ: begin
              if (!first_tx_r && in_nack) begin
                in_read_nxt  = 1'b0;
                first_tx_nxt = 1'b0;
                if (resp_len_r != '0 && tx_idx_r >= resp_len_r) begin
                  consumed_nxt = 1'b1;
                end
                emit_cmd = i2ctfb_pkg::CMD_DONE;
              end else begin
                first_tx_nxt = 1'b0;
                if (tx_hit) begin
                  tx_idx_nxt = tx_idx_r + TX_CW'(1);
                  state_nxt  = S_TXRD;
                  emit       = 1'b0;
                end else begin
                  emit_cmd   = i2ctfb_pkg::CMD_ACK;
                  emit_rbyte = i2ctfb_pkg::FILLER_BYTE;
                end
              end
            end
            i2ctfb_pkg::ACT_TAKE_FRAME: begin
              if (parked_r) begin
                parked_nxt    = 1'b0;
                awaiting_nxt  = 1'b1;
                resp_len_nxt  = '0;
                consumed_nxt  = 1'b0;
                load_ptr_nxt  = '0;
                fr_len_nxt    = parked_len_r;
                rd_idx_nxt    = '0;
                pend_nxt      = 1'b0;
                pend_last_nxt = 1'b0;
                state_nxt     = S_FRAME;
                emit          = 1'b0;
              end
            end
            i2ctfb_pkg::ACT_RESP_BYTE: begin
              if (load_ptr_r < TX_CW'(TX_DEPTH)) begin
                load_ptr_nxt = load_ptr_r + TX_CW'(1);
              end
              if (in_tlast) begin
                resp_len_nxt = load_ptr_nxt;
                tx_idx_nxt   = '0;
                consumed_nxt = 1'b0;
                awaiting_nxt = 1'b0;
                load_ptr_nxt = '0;
              end
            end
            i2ctfb_pkg::ACT_ARM_EMPTY: begin
              resp_len_nxt = '0;
              tx_idx_nxt   = '0;
              consumed_nxt = 1'b0;
              awaiting_nxt = 1'b0;
              load_ptr_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_TXRD: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_cmd   = i2ctfb_pkg::CMD_ACK;
          emit_rbyte = tx_rdata_r;
          state_nxt  = S_IDLE;
        end
      end
      S_FRAME: begin
        if (pend_r && out_free) begin
          out_tvalid_nxt = 1'b1;
          out_cmd_nxt    = i2ctfb_pkg::CMD_HOLD;
          out_rbyte_nxt  = '0;
          out_fvalid_nxt = 1'b1;
          out_fbyte_nxt  = rx_rdata_r;
          out_flen_nxt   = LW'(fr_len_r);
          out_last_nxt   = pend_last_r;
          out_cons_nxt   = consumed_r;
          pend_nxt       = 1'b0;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (rx_re) begin
          rd_idx_nxt    = rd_idx_r + RX_CW'(1);
          pend_nxt      = 1'b1;
          pend_last_nxt = ((rd_idx_r + RX_CW'(1)) == fr_len_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_cmd_nxt    = emit_cmd;
      out_rbyte_nxt  = emit_rbyte;
      out_fvalid_nxt = 1'b0;
      out_fbyte_nxt  = '0;
      out_flen_nxt   = '0;
      out_last_nxt   = 1'b1;
      out_cons_nxt   = consumed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rx_count_r   <= '0;
      parked_len_r <= '0;
      rx_ovf_r     <= 1'b0;
      parked_r     <= 1'b0;
      in_write_r   <= 1'b0;
      awaiting_r   <= 1'b0;
      resp_len_r   <= '0;
      tx_idx_r     <= '0;
      load_ptr_r   <= '0;
      first_tx_r   <= 1'b0;
      in_read_r    <= 1'b0;
      consumed_r   <= 1'b0;
      fr_len_r     <= '0;
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      pend_last_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rx_count_r   <= rx_count_nxt;
      parked_len_r <= parked_len_nxt;
      rx_ovf_r     <= rx_ovf_nxt;
      parked_r     <= parked_nxt;
      in_write_r   <= in_write_nxt;
      awaiting_r   <= awaiting_nxt;
      resp_len_r   <= resp_len_nxt;
      tx_idx_r     <= tx_idx_nxt;
      load_ptr_r   <= load_ptr_nxt;
      first_tx_r   <= first_tx_nxt;
      in_read_r    <= in_read_nxt;
      consumed_r   <= consumed_nxt;
      fr_len_r     <= fr_len_nxt;
      rd_idx_r     <= rd_idx_nxt;
      pend_r       <= pend_nxt;
      pend_last_r  <= pend_last_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cmd_r    <= out_cmd_nxt;
    out_rbyte_r  <= out_rbyte_nxt;
    out_fvalid_r <= out_fvalid_nxt;
    out_fbyte_r  <= out_fbyte_nxt;
    out_flen_r   <= out_flen_nxt;
    out_last_r   <= out_last_nxt;
    out_cons_r   <= out_cons_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_cons_r, out_flen_r, out_fbyte_r, out_rbyte_r, out_cmd_r};
  assign out_tuser  = out_fvalid_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- verif/tb_i2c_target_frame_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_target_frame_buffer
// Self-checking bench for the I2C target frame buffer. Bus events and host
// commands go in as stream beats. A cycle-free model of the buffer predicts
// every result beat, and each beat leaving the block is compared field by
// field. Directed cases come first, then randomised write, take, reply and
// read transactions mixed with noise, under several idle and stall profiles.
// ----------------------------------------------------------------------------
module tb_i2c_target_frame_buffer;

  localparam int unsigned RXD = i2ctfb_pkg::RX_DEPTH_DEF;
  localparam int unsigned TXD = i2ctfb_pkg::TX_DEPTH_DEF;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] rbyte;
    logic       fvalid;
    logic [7:0] fbyte;
    logic [6:0] flen;
    logic       lastrun;
    logic       consumed;
  } reply_beat_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [i2ctfb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [i2ctfb_pkg::ACTION_W-1:0]   in_tuser = '0;
  logic                              in_tlast = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [i2ctfb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                              out_tuser;
  logic                              out_tlast;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_taken = 0;
  int unsigned errors = 0;

  reply_beat_t expected_beats[$];
  reply_beat_t want;

  logic [7:0]  rx_mem [RXD];
  logic [7:0]  tx_mem [TXD];
  int unsigned rx_cnt = 0;
  int unsigned parked_len = 0;
  int unsigned resp_len = 0;
  int unsigned tx_idx = 0;
  int unsigned load_ptr = 0;
  bit          rx_ovf = 0;
  bit          parked = 0;
  bit          in_wr = 0;
  bit          wait_resp = 0;
  bit          first_tx = 0;
  bit          in_rd = 0;
  bit          consumed = 0;

  i2c_target_frame_buffer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("i2c_target_frame_buffer: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void end_read();
    in_rd = 0;
    first_tx = 0;
    if (resp_len != 0 && tx_idx >= resp_len) consumed = 1;
  endfunction

  function automatic void close_frame();
    in_wr = 0;
    if (rx_cnt != 0 && !rx_ovf) begin
      parked = 1;
      parked_len = rx_cnt;
    end
    rx_cnt = 0;
    rx_ovf = 0;
  endfunction

  function automatic void predict_reply(logic [3:0] act, logic [7:0] data, logic nack,
                                        logic last);
    reply_beat_t b;
    int unsigned n;
    b = '{cmd: i2ctfb_pkg::CMD_HOLD, rbyte: 8'h00, fvalid: 1'b0, fbyte: 8'h00,
          flen: 7'd0, lastrun: 1'b1, consumed: 1'b0};
    case (act)
      i2ctfb_pkg::ACT_BUS_ERROR: begin
        rx_cnt = 0;
        rx_ovf = 0;
        in_wr = 0;
        in_rd = 0;
        first_tx = 0;
      end
      i2ctfb_pkg::ACT_ADDR_WRITE, i2ctfb_pkg::ACT_ADDR_READ: begin
        if (in_wr) close_frame();
        if (!(parked || wait_resp)) begin
          if (act == i2ctfb_pkg::ACT_ADDR_READ) begin
            first_tx = 1;
            tx_idx = 0;
            in_rd = 1;
          end else begin
            in_wr = 1;
            rx_cnt = 0;
            rx_ovf = 0;
            resp_len = 0;
          end
          b.cmd = i2ctfb_pkg::CMD_ACK;
        end
      end
      i2ctfb_pkg::ACT_STOP: begin
        if (in_rd) end_read();
        if (in_wr) close_frame();
        b.cmd = i2ctfb_pkg::CMD_DONE;
      end
      i2ctfb_pkg::ACT_WRITE_BYTE: begin
        if (in_wr) begin
          if (rx_cnt < RXD) begin
            rx_mem[rx_cnt] = data;
            rx_cnt++;
          end else begin
            rx_ovf = 1;
          end
        end
        b.cmd = i2ctfb_pkg::CMD_ACK;
      end
      i2ctfb_pkg::ACT_BYTE_REQ: begin
        if (!first_tx && nack) begin
          end_read();
          b.cmd = i2ctfb_pkg::CMD_DONE;
        end else begin
          first_tx = 0;
          if (tx_idx < resp_len && tx_idx < TXD) begin
            b.rbyte = tx_mem[tx_idx];
            tx_idx++;
          end else begin
            b.rbyte = i2ctfb_pkg::FILLER_BYTE;
          end
          b.cmd = i2ctfb_pkg::CMD_ACK;
        end
      end
      i2ctfb_pkg::ACT_TAKE_FRAME: begin
        if (parked) begin
          n = (parked_len > RXD) ? RXD : parked_len;
          parked = 0;
          wait_resp = 1;
          resp_len = 0;
          consumed = 0;
          load_ptr = 0;
          frames_taken++;
          b.fvalid = 1'b1;
          b.flen = n[6:0];
          for (int unsigned i = 0; i < n; i++) begin
            b.fbyte = rx_mem[i];
            b.lastrun = (i + 1 == n);
            expected_beats.push_back(b);
          end
          if (n == 0) expected_beats.push_back(b);
          return;
        end
      end
      i2ctfb_pkg::ACT_RESP_BYTE: begin
        if (load_ptr < TXD) begin
          tx_mem[load_ptr] = data;
          load_ptr++;
        end
        if (last) begin
          resp_len = load_ptr;
          tx_idx = 0;
          consumed = 0;
          wait_resp = 0;
          load_ptr = 0;
        end
      end
      i2ctfb_pkg::ACT_ARM_EMPTY: begin
        resp_len = 0;
        tx_idx = 0;
        consumed = 0;
        wait_resp = 0;
        load_ptr = 0;
      end
      default: ;
    endcase
    b.consumed = consumed;
    expected_beats.push_back(b);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got);
    if (got !== exp_v) begin
      $error("%s expected %0h got %0h", name, exp_v, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected, tdata %0h", out_tdata);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        check_field("bus_command", 8'(want.cmd), 8'(out_tdata[1:0]));
        check_field("read_byte", want.rbyte, out_tdata[9:2]);
        check_field("frame_byte", want.fbyte, out_tdata[17:10]);
        check_field("frame_length", 8'(want.flen), 8'(out_tdata[24:18]));
        check_field("response_consumed", 8'(want.consumed), 8'(out_tdata[25]));
        check_field("frame_valid", 8'(want.fvalid), 8'(out_tuser));
        check_field("last_of_run", 8'(want.lastrun), 8'(out_tlast));
      end
    end
  end

  task automatic send_item(input logic [3:0] act, input logic [7:0] data = 8'h00,
                           input logic nack = 1'b0, input logic last = 1'b0);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = {7'd0, nack, data};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    predict_reply(act, data, nack, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int unsigned pick_len();
    return ($urandom_range(11) == 0) ? $urandom_range(66, 62) : $urandom_range(8);
  endfunction

  task automatic test_reset_and_stray_events();
    send_item(4'd15, 8'hFF, 1'b1, 1'b1);
    send_item(4'd9);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b0);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b1);
    send_item(i2ctfb_pkg::ACT_WRITE_BYTE, 8'hFF);
    send_item(i2ctfb_pkg::ACT_TAKE_FRAME);
    send_item(i2ctfb_pkg::ACT_ARM_EMPTY);
  endtask

  task automatic test_frame_round_trip();
    send_item(i2ctfb_pkg::ACT_ADDR_WRITE);
    send_item(i2ctfb_pkg::ACT_WRITE_BYTE, 8'h00);
    send_item(i2ctfb_pkg::ACT_WRITE_BYTE, 8'hFF);
    send_item(i2ctfb_pkg::ACT_WRITE_BYTE, 8'h5A);
    // repeated start parks the frame, then the read is held
    send_item(i2ctfb_pkg::ACT_ADDR_READ);
    send_item(i2ctfb_pkg::ACT_BUS_ERROR);
    send_item(i2ctfb_pkg::ACT_TAKE_FRAME);
    send_item(i2ctfb_pkg::ACT_TAKE_FRAME);
    send_item(i2ctfb_pkg::ACT_RESP_BYTE, 8'h00);
    send_item(i2ctfb_pkg::ACT_RESP_BYTE, 8'hFF, 1'b0, 1'b1);
    send_item(i2ctfb_pkg::ACT_ADDR_READ);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b1);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b0);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b0);
    send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'h00, 1'b1);
    send_item(i2ctfb_pkg::ACT_STOP);
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall,
                                     int unsigned n_items);
    int unsigned start;
    int unsigned len;
    start = items_sent;
    in_idle_pct = idle;
    out_stall_pct = stall;
    while (items_sent - start < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          send_item(i2ctfb_pkg::ACT_ADDR_WRITE, 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
          len = pick_len();
          repeat (len) send_item(i2ctfb_pkg::ACT_WRITE_BYTE, 8'($urandom_range(255)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
          case ($urandom_range(5))
            0: send_item(i2ctfb_pkg::ACT_ADDR_WRITE);
            1: send_item(i2ctfb_pkg::ACT_ADDR_READ);
            2: send_item(i2ctfb_pkg::ACT_BUS_ERROR);
            default: send_item(i2ctfb_pkg::ACT_STOP);
          endcase
        end
        3, 4: begin
          send_item(i2ctfb_pkg::ACT_TAKE_FRAME, 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
          len = pick_len();
          if (len == 0) send_item(i2ctfb_pkg::ACT_ARM_EMPTY, 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
          for (int unsigned k = 0; k < len; k++)
            send_item(i2ctfb_pkg::ACT_RESP_BYTE, 8'($urandom_range(255)),
                      1'($urandom_range(1)),
                      (k + 1 == len) && ($urandom_range(7) != 0));
        end
        5, 6, 7: begin
          send_item(i2ctfb_pkg::ACT_ADDR_READ);
          len = $urandom_range(1, 6);
          send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          repeat (len - 1) send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'($urandom_range(255)),
                                     $urandom_range(5) == 0);
          send_item(i2ctfb_pkg::ACT_BYTE_REQ, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          if ($urandom_range(4) != 0) send_item(i2ctfb_pkg::ACT_STOP);
        end
        default: begin
          repeat ($urandom_range(1, 3))
            send_item(4'($urandom_range(15)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_and_stray_events();
    test_frame_round_trip();
    drain_results();
    test_random_traffic(0, 0, 45);
    drain_results();
    test_random_traffic(77, 0, 45);
    drain_results();
    test_random_traffic(0, 77, 45);
    drain_results();
    test_random_traffic(34, 34, 45);
    drain_results();
    $display("Sent %0d bus events and host commands, checked %0d result beats,",
             items_sent, beats_checked);
    $display("and %0d parked frames were read back.", frames_taken);
    if (errors == 0) begin
      $display("i2c_target_frame_buffer: match");
    end else begin
      $display("i2c_target_frame_buffer: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/i2ctfb_pkg.sv
rtl/core/i2c_target_frame_buffer.sv
verif/tb_i2c_target_frame_buffer.sv
